[rtl/hid_boot_keyboard_to_scancode_events_top_assert.svh]
// Assertion macros for the boot keyboard to scancode converter.
// Included by the top level; needs no package.
`ifndef HID_BOOT_KEYBOARD_TO_SCANCODE_EVENTS_TOP_ASSERT_SVH
`define HID_BOOT_KEYBOARD_TO_SCANCODE_EVENTS_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HBK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define HBK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HBK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define HBK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/hbk_pkg.sv]
// Shared types, constants and lookup tables for the boot keyboard converter.
// Used by the controller, the datapath and the top level; depends on nothing.
package hbk_pkg;

  localparam int KEY_SLOTS      = 6;
  localparam int KEYMAP_ENTRIES = 102;
  localparam int KM_W           = $clog2(KEYMAP_ENTRIES);

  localparam int MOD_BITS     = 8;
  localparam int MOD_REL_BASE = KEY_SLOTS;
  localparam int MOD_PRS_BASE = KEY_SLOTS + MOD_BITS;
  localparam int KEY_PRS_BASE = KEY_SLOTS + 2 * MOD_BITS;
  localparam int NUM_STEPS    = 2 * KEY_SLOTS + 2 * MOD_BITS;
  localparam int STEP_W       = $clog2(NUM_STEPS);

  localparam logic [1:0] KIND_REPORT     = 2'd0;
  localparam logic [1:0] KIND_CONNECT    = 2'd1;
  localparam logic [1:0] KIND_DISCONNECT = 2'd2;

  localparam logic [7:0] RELEASE_BIT = 8'h80;

  localparam logic [6:0] USAGE_TABLE [KEYMAP_ENTRIES] = '{
    7'd0, 7'd0, 7'd0, 7'd0,
    7'd30, 7'd48, 7'd46, 7'd32, 7'd18, 7'd33, 7'd34, 7'd35, 7'd23, 7'd36,
    7'd37, 7'd38, 7'd50, 7'd49, 7'd24, 7'd25, 7'd16, 7'd19, 7'd31, 7'd20,
    7'd22, 7'd47, 7'd17, 7'd45, 7'd21, 7'd44,
    7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd11,
    7'd28, 7'd1, 7'd14, 7'd15, 7'd57,
    7'd12, 7'd13, 7'd26, 7'd27, 7'd43, 7'd0, 7'd39, 7'd40, 7'd41, 7'd51,
    7'd52, 7'd53,
    7'd58,
    7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68,
    7'd0, 7'd0,
    7'd0, 7'd0, 7'd0,
    7'd82, 7'd71, 7'd73, 7'd83, 7'd79, 7'd81, 7'd77, 7'd75, 7'd80, 7'd72,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
  };

  localparam logic [6:0] MOD_TABLE [MOD_BITS] = '{
    7'd29, 7'd42, 7'd56, 7'd0, 7'd29, 7'd54, 7'd56, 7'd0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic       report_complete;
    logic [7:0] modifiers;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } hbk_rpt_t;

  typedef struct packed {
    logic [7:0] event_code;
    logic       last_event;
  } hbk_evt_t;

  typedef struct packed {
    logic clear;
    logic drop;
    logic load;
    logic step;
  } hbk_cmd_t;

  typedef struct packed {
    logic connected;
    logic new_any;
    logic cur_hit;
    logic rest_empty;
    logic out_free;
  } hbk_sts_t;

  function automatic logic [6:0] usage_code(input logic [7:0] usage);
    return ({1'b0, usage} < 9'(KEYMAP_ENTRIES)) ? USAGE_TABLE[usage[KM_W-1:0]] : 7'd0;
  endfunction

endpackage

[rtl/hid_boot_keyboard_to_scancode_events_top.sv]
// Top level of the boot keyboard report to set-1 scancode converter.
// Joins hbk_ctrl and hbk_dp; uses hbk_pkg and the assertion macro header.
//
// A report is taken in the cycle that compares it with the stored
// report and builds a mask of the 28 possible events (six key releases,
// eight modifier releases, eight modifier presses, six key presses). The
// scan index then walks that mask one position per cycle, holding at an
// event while the output register is still stalled, and the scan ends at
// the report's last event. Connect, disconnect, ignored items and reports
// with no change start no scan. The final event of a report is sent with
// last_event set, and the next item can be taken while it still waits in
// the output register.
`include "hid_boot_keyboard_to_scancode_events_top_assert.svh"

module hid_boot_keyboard_to_scancode_events_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              rpt_valid,
  output logic              rpt_stall,
  input  hbk_pkg::hbk_rpt_t rpt,
  output logic              evt_valid,
  input  logic              evt_stall,
  output hbk_pkg::hbk_evt_t evt
);
  import hbk_pkg::*;

  hbk_cmd_t cmd;
  hbk_sts_t sts;
  logic     busy;

  hbk_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .rpt_valid       (rpt_valid),
    .kind            (rpt.kind),
    .report_complete (rpt.report_complete),
    .sts             (sts),
    .cmd             (cmd),
    .busy            (busy)
  );

  hbk_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rpt       (rpt),
    .cmd       (cmd),
    .sts       (sts),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  assign rpt_stall = busy;

  `HBK_ASSERT_IMP(a_step_only_busy, clk, rst, cmd.step, rpt_stall, "step while idle")
  `HBK_ASSERT_IMP(a_one_command, clk, rst, 1'b1, $onehot0(cmd), "commands overlap")
  `HBK_ASSERT_NEXT(a_load_runs, clk, rst, cmd.load && sts.new_any, rpt_stall,
    "scan did not start")
  `HBK_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.step && sts.cur_hit, evt_valid,
    "event lost")

endmodule

[rtl/hbk_ctrl.sv]
// Controller state machine for the boot keyboard converter.
// Decodes item kinds and sequences the event scan; uses hbk_pkg.
module hbk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              rpt_valid,
  input  logic [1:0]        kind,
  input  logic              report_complete,
  input  hbk_pkg::hbk_sts_t sts,
  output hbk_pkg::hbk_cmd_t cmd,
  output logic              busy
);
  import hbk_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   step_ok;

  assign busy    = (state != ST_IDLE);
  assign accept  = rpt_valid && (state == ST_IDLE);
  assign step_ok = !sts.cur_hit || sts.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_CONNECT:    cmd.clear = 1'b1;
            KIND_DISCONNECT: cmd.drop  = 1'b1;
            KIND_REPORT: begin
              if (report_complete && sts.connected) begin
                cmd.load = 1'b1;
                if (sts.new_any) begin
                  state_next = ST_RUN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.step = step_ok;
        if (step_ok && sts.rest_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/hbk_dp.sv]
// Datapath for the boot keyboard converter: stored report, event mask,
// scan index and output register. Uses hbk_pkg.
module hbk_dp (
  input  logic              clk,
  input  logic              rst,
  input  hbk_pkg::hbk_rpt_t rpt,
  input  hbk_pkg::hbk_cmd_t cmd,
  output hbk_pkg::hbk_sts_t sts,
  output logic              evt_valid,
  input  logic              evt_stall,
  output hbk_pkg::hbk_evt_t evt
);
  import hbk_pkg::*;

  logic                 connected;
  logic [7:0]           last_modifier;
  logic [7:0]           last_keys [KEY_SLOTS];
  logic [6:0]           rel_code [KEY_SLOTS];
  logic [6:0]           prs_code [KEY_SLOTS];
  logic [7:0]           mod_now;
  logic [7:0]           mod_old;
  logic [NUM_STEPS-1:0] mask;
  logic [STEP_W-1:0]    idx;

  logic [7:0]           slot_all [6];
  logic [7:0]           in_keys [KEY_SLOTS];
  logic [6:0]           rel_code_c [KEY_SLOTS];
  logic [6:0]           prs_code_c [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] old_hit;
  logic [KEY_SLOTS-1:0] new_hit;
  logic [7:0]           changed;
  logic [NUM_STEPS-1:0] new_mask;
  logic [7:0]           code_all [NUM_STEPS];
  logic [7:0]           cur_code;
  logic [NUM_STEPS-1:0] rest;

  assign slot_all[0] = rpt.key_slot_0;
  assign slot_all[1] = rpt.key_slot_1;
  assign slot_all[2] = rpt.key_slot_2;
  assign slot_all[3] = rpt.key_slot_3;
  assign slot_all[4] = rpt.key_slot_4;
  assign slot_all[5] = rpt.key_slot_5;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      in_keys[i] = slot_all[i];
    end
  end

  // A key is present in the other report if any slot there holds it.
  always_comb begin
    old_hit  = '0;
    new_hit  = '0;
    new_mask = '0;
    changed  = last_modifier ^ rpt.modifiers;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (in_keys[j] == last_keys[i]) begin
          old_hit[i] = 1'b1;
        end
        if (last_keys[j] == in_keys[i]) begin
          new_hit[i] = 1'b1;
        end
      end
      rel_code_c[i] = usage_code(last_keys[i]);
      prs_code_c[i] = usage_code(in_keys[i]);
      new_mask[i] = (last_keys[i] != 8'd0) && !old_hit[i] && (rel_code_c[i] != 7'd0);
      new_mask[KEY_PRS_BASE + i] = (in_keys[i] != 8'd0) && !new_hit[i] &&
                                   (prs_code_c[i] != 7'd0);
    end
    for (int b = 0; b < MOD_BITS; b++) begin
      new_mask[MOD_REL_BASE + b] = changed[b] && !rpt.modifiers[b] &&
                                   (MOD_TABLE[b] != 7'd0);
      new_mask[MOD_PRS_BASE + b] = changed[b] && rpt.modifiers[b] &&
                                   (MOD_TABLE[b] != 7'd0);
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      code_all[i]                = RELEASE_BIT | {1'b0, rel_code[i]};
      code_all[KEY_PRS_BASE + i] = {1'b0, prs_code[i]};
    end
    for (int b = 0; b < MOD_BITS; b++) begin
      code_all[MOD_REL_BASE + b] = mod_old[b] ? (RELEASE_BIT | {1'b0, MOD_TABLE[b]}) : 8'd0;
      code_all[MOD_PRS_BASE + b] = mod_now[b] ? {1'b0, MOD_TABLE[b]} : 8'd0;
    end
  end

  always_comb begin
    cur_code = '0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      if (idx == STEP_W'(i)) begin
        cur_code = code_all[i];
      end
    end
  end

  assign rest = mask >> idx;

  assign sts.connected  = connected;
  assign sts.new_any    = (new_mask != '0);
  assign sts.cur_hit    = mask[idx];
  assign sts.rest_empty = ((rest >> 1) == '0);
  assign sts.out_free   = !evt_valid || !evt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      connected     <= 1'b0;
      last_modifier <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        last_keys[i] <= '0;
      end
      mask          <= '0;
      idx           <= '0;
      evt_valid     <= 1'b0;
    end else begin
      if (cmd.clear) begin
        connected     <= 1'b1;
        last_modifier <= '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          last_keys[i] <= '0;
        end
      end
      if (cmd.drop) begin
        connected <= 1'b0;
      end
      if (cmd.load) begin
        last_modifier <= rpt.modifiers;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          last_keys[i] <= in_keys[i];
        end
        mask <= new_mask;
        idx  <= '0;
      end else if (cmd.step) begin
        idx <= idx + STEP_W'(1);
      end
      if (cmd.step && sts.cur_hit) begin
        evt_valid <= 1'b1;
      end else if (evt_valid && !evt_stall) begin
        evt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_now <= rpt.modifiers & changed;
      mod_old <= ~rpt.modifiers & changed;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        rel_code[i] <= rel_code_c[i];
        prs_code[i] <= prs_code_c[i];
      end
    end
    if (cmd.step && sts.cur_hit) begin
      evt.event_code <= cur_code;
      evt.last_event <= sts.rest_empty;
    end
  end

endmodule
